/* hdl/uitp_pkg.sv */
// ----------------------------------------------------------------------------
// uitp_pkg
// Types, codes and character constants shared by the integer text parser.
// ----------------------------------------------------------------------------
package uitp_pkg;

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int BASE_W   = 2;
	localparam int MASK_W   = 4;
	localparam int DIGIT_W  = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	typedef enum logic [BASE_W-1:0] {
		BASE_BIN = 2'd0,
		BASE_OCT = 2'd1,
		BASE_DEC = 2'd2,
		BASE_HEX = 2'd3
	} base_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_INVALID  = 2'd1,
		STATUS_BASE_OFF = 2'd2
	} status_t;

	// Register indexes on the configuration port
	localparam logic REG_BASE_MASK = 1'b0;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_B  = 8'h42;
	localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
	localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

	// Digit value of a character; DIGIT_NONE for anything that is no digit
	function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = DIGIT_W'(c - CH_ZERO);
		end else if (c >= CH_LC_A && c <= CH_LC_F) begin
			d = DIGIT_W'(c - CH_LC_A) + 5'd10;
		end else if (c >= CH_UC_A && c <= CH_UC_F) begin
			d = DIGIT_W'(c - CH_UC_A) + 5'd10;
		end
		return d;
	endfunction

endpackage

/* hdl/uitp_if.sv */
// ----------------------------------------------------------------------------
// uitp_char_if / uitp_result_if
// Valid/ready channels for token characters and parse results.
// ----------------------------------------------------------------------------
interface uitp_char_if
	import uitp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface uitp_result_if
	import uitp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0] status;
	logic [BASE_W-1:0]   found_base;

	modport source (output valid, output value, output status, output found_base,
		input ready);
	modport sink   (input valid, input value, input status, input found_base,
		output ready);
endinterface

/* hdl/uitp_digit_step.sv */
// ----------------------------------------------------------------------------
// uitp_digit_step
// One digit of accumulation: acc * radix + digit, with digit and range check.
// ----------------------------------------------------------------------------
module uitp_digit_step
	import uitp_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic [VALUE_BITS-1:0] acc,
	input  base_t                 base,
	input  logic [CHAR_W-1:0]     char_code,
	output logic [VALUE_BITS-1:0] acc_next,
	output logic                  ok
);

	localparam int WIDE_W = VALUE_BITS + 4;

	logic [DIGIT_W-1:0] digit;
	logic [WIDE_W-1:0]  acc_w;
	logic [WIDE_W-1:0]  scaled;
	logic [WIDE_W-1:0]  sum;
	logic               in_radix;

	assign digit = digit_value(char_code);
	assign acc_w = WIDE_W'(acc);

	// Radix multiply as shifts; decimal is x8 + x2
	always_comb begin
		case (base)
			BASE_BIN: begin
				scaled   = acc_w << 1;
				in_radix = (digit < 5'd2);
			end
			BASE_OCT: begin
				scaled   = acc_w << 3;
				in_radix = (digit < 5'd8);
			end
			BASE_DEC: begin
				scaled   = (acc_w << 3) + (acc_w << 1);
				in_radix = (digit < 5'd10);
			end
			default: begin
				scaled   = acc_w << 4;
				in_radix = (digit < 5'd16);
			end
		endcase
	end

	assign sum      = scaled + WIDE_W'(digit);
	assign acc_next = sum[VALUE_BITS-1:0];
	// Anything in the top four bits means the value left the range
	assign ok       = in_radix && (sum[WIDE_W-1:VALUE_BITS] == 4'd0);

endmodule

/* hdl/unsigned_integer_text_parser.sv */
// ----------------------------------------------------------------------------
// unsigned_integer_text_parser
// Parses one numeric token, one character per item, into an unsigned value.
// ----------------------------------------------------------------------------
// Usage:
//   chars   - valid/ready channel, one ASCII character per item; is_last marks
//             the final character of a token. Every token has one character
//             at least.
//   results - valid/ready channel, one item per token: value, status
//             (ok / invalid / base not allowed) and found_base.
//   APB     - register base_mask (4-bit mask, bit0 binary .. bit3 hex)
//             at byte address 0. Write it only while no token is in flight.
// Base comes from the prefix: 0b/0B binary, 0x/0X hex, other leading 0
// octal, else decimal with an optional leading '+'.
// Throughput: one character per cycle, sustained while no last character
// stalls behind an untaken result. Each character is registered, then the
// shift-add and range check update the token state and load the output
// register, so the result item is offered once its last character has
// passed through the input register and the output register. The output
// register lets the next token stream in while a result waits.
// Reset clears the token state and enables all bases in the mask.
// ----------------------------------------------------------------------------
module unsigned_integer_text_parser
	import uitp_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	uitp_char_if.sink          chars,
	uitp_result_if.source      results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	// ---------------- configuration ----------------
	logic [MASK_W-1:0] base_mask_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BASE_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mask_q <= 4'hF;
		end else if (cfg_wr) begin
			base_mask_q <= pwdata[MASK_W-1:0];
		end
	end

	// Only one register; other indexes read as zero
	assign prdata = (paddr[2] == REG_BASE_MASK) ? APB_DW'(base_mask_q) : '0;

	// ---------------- input register ----------------
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;
	logic              out_valid_q;

	// A non-last character never produces a result, so it moves on even
	// while the output register is full; a last one waits for a free slot.
	assign advance      = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign chars.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	// ---------------- token state ----------------
	logic [1:0]            pos_q;
	base_t                 base_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  err_q;
	logic                  seen_q;
	logic                  fwz_q;

	logic [1:0]            pos_n;
	base_t                 base_n;
	logic [VALUE_BITS-1:0] acc_n;
	logic                  err_n;
	logic                  seen_n;
	logic                  fwz_n;

	base_t                 step_base;
	logic [VALUE_BITS-1:0] step_acc;
	logic                  step_ok;
	logic                  prefix_pos;

	// Second character after a leading zero decides between the prefixes
	// and octal; an octal digit there is already scaled by 8.
	assign prefix_pos = (pos_q == 2'd1) && fwz_q;
	assign step_base  = prefix_pos ? BASE_OCT : base_q;

	uitp_digit_step #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.acc       (acc_q),
		.base      (step_base),
		.char_code (char_s1),
		.acc_next  (step_acc),
		.ok        (step_ok)
	);

	always_comb begin
		logic take_digit;
		take_digit = 1'b0;
		base_n     = base_q;
		acc_n      = acc_q;
		err_n      = err_q;
		seen_n     = seen_q;
		fwz_n      = fwz_q;

		if (!err_q) begin
			if (pos_q == 2'd0) begin
				if (char_s1 inside {CH_SPACE, [CH_TAB:CH_CR], CH_MINUS}) begin
					// reject leading whitespace and minus sign
					err_n = 1'b1;
				end else if (char_s1 == CH_ZERO) begin
					fwz_n  = 1'b1;
					seen_n = 1'b1;
				end else if (char_s1 != CH_PLUS) begin
					take_digit = 1'b1;
				end
			end else if (prefix_pos) begin
				if (char_s1 inside {CH_LC_B, CH_UC_B}) begin
					base_n = BASE_BIN;
					seen_n = 1'b0;
				end else if (char_s1 inside {CH_LC_X, CH_UC_X}) begin
					base_n = BASE_HEX;
					seen_n = 1'b0;
				end else begin
					base_n     = BASE_OCT;
					take_digit = 1'b1;
				end
			end else begin
				take_digit = 1'b1;
			end

			if (take_digit) begin
				if (step_ok) begin
					acc_n  = step_acc;
					seen_n = 1'b1;
				end else begin
					err_n = 1'b1;
				end
			end
		end

		// saturate at two: only the first two positions matter
		pos_n = (pos_q == 2'd2) ? pos_q : pos_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			base_q <= BASE_DEC;
			acc_q  <= '0;
			err_q  <= 1'b0;
			seen_q <= 1'b0;
			fwz_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// token done: drop back to the start state
				pos_q  <= 2'd0;
				base_q <= BASE_DEC;
				acc_q  <= '0;
				err_q  <= 1'b0;
				seen_q <= 1'b0;
				fwz_q  <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				base_q <= base_n;
				acc_q  <= acc_n;
				err_q  <= err_n;
				seen_q <= seen_n;
				fwz_q  <= fwz_n;
			end
		end
	end

	// ---------------- result ----------------
	status_t            status_c;
	logic [VALUE_W-1:0] value_c;
	logic               lone_zero;

	// The token "0" is fine whatever the mask says
	assign lone_zero = fwz_n && (base_n == BASE_DEC);

	always_comb begin
		status_c = STATUS_OK;
		value_c  = '0;
		if (err_n || !seen_n) begin
			status_c = STATUS_INVALID;
		end else if (lone_zero) begin
			status_c = STATUS_OK;
		end else if (!base_mask_q[base_n]) begin
			status_c = STATUS_BASE_OFF;
		end else begin
			value_c = VALUE_W'(acc_n);
		end
	end

	logic [VALUE_W-1:0]  value_q;
	logic [STATUS_W-1:0] status_q;
	logic [BASE_W-1:0]   found_base_q;
	logic                load_out;

	assign load_out = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q      <= value_c;
			status_q     <= status_c;
			found_base_q <= base_n;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.value      = value_q;
	assign results.status     = status_q;
	assign results.found_base = found_base_q;

endmodule
